[hw/rtl/cascade_split_frustum_cull_defines.svh]
// ----------------------------------------------------------------------------
// Cascade split cull - assertion macros
// Shared assertion wrappers for the checker of the cull block.
// ----------------------------------------------------------------------------
`ifndef CASCADE_SPLIT_FRUSTUM_CULL_DEFINES_SVH
`define CASCADE_SPLIT_FRUSTUM_CULL_DEFINES_SVH

// Check on the rising clock, muted while reset is asserted.
`define CSFC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("csfc check failed");

// Check on the rising clock, also active during reset.
`define CSFC_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("csfc check failed");

`endif

[hw/rtl/csfc_pkg.sv]
// ----------------------------------------------------------------------------
// Cascade split cull - package
// Command codes, register indexes, widths and the control word that travels
// along the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csfc_pkg;

    // fixed field widths
    localparam int NORM_W    = 16;   // stored Q1.15 normal
    localparam int OFS_W     = 41;   // plane offset, 15 fraction bits
    localparam int RAD_W     = 17;   // sphere radius
    localparam int FRAC_BITS = 15;
    localparam int PLANES    = 4;    // planes per split
    localparam int MASK_W    = 8;    // covers the largest split count
    localparam int DATA_W    = 32;   // config data bus
    localparam int ADDR_W    = 3;

    typedef enum logic [1:0] {
        CMD_WRITE_PLANE = 2'd0,
        CMD_TEST_BOX    = 2'd1,
        CMD_TEST_SPHERE = 2'd2
    } t_cmd;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_SPLIT_COUNT = 1'b0,
        REG_CULL_ENABLE = 1'b1
    } t_reg;

    // control word handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              sphere;
        logic              done;     // object fully inside an earlier split, or culling off
        logic [MASK_W-1:0] mask;
    } t_ctrl;

    // clamp a write value to the Q1.15 range
    function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [32:0] v);
        logic signed [NORM_W-1:0] res;
        if (v > 33'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -33'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[NORM_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/csfc_cell.sv]
// ----------------------------------------------------------------------------
// Cascade split cull - split cell
// Holds the four planes of one split. Stage 1 forms all normal-by-corner
// products, stage 2 sums them into plane distances and updates the mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csfc_cell
    import csfc_pkg::*;
#(
    parameter int COORD_BITS = 18,
    parameter int CELL_IDX   = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_adv,
    input  wire logic                         i_wr_en,
    input  wire logic [1:0]                   i_wr_plane,
    input  wire logic [2:0][NORM_W-1:0]       i_wr_normal,
    input  wire logic [OFS_W-1:0]             i_wr_offset,
    input  wire t_ctrl                        i_ctrl,
    input  wire logic [2:0][COORD_BITS-1:0]   i_lo,
    input  wire logic [2:0][COORD_BITS-1:0]   i_hi,
    input  wire logic [RAD_W-1:0]             i_rad,
    output t_ctrl                             o_ctrl,
    output logic [2:0][COORD_BITS-1:0]        o_lo,
    output logic [2:0][COORD_BITS-1:0]        o_hi,
    output logic [RAD_W-1:0]                  o_rad
);

    localparam int PW = NORM_W + COORD_BITS;
    localparam int SW = (PW + 2 > OFS_W) ? PW + 2 : OFS_W;
    localparam int DW = SW + 1;
    localparam logic [MASK_W-1:0] KEEP_MASK = MASK_W'((2 << CELL_IDX) - 1);

    logic signed [NORM_W-1:0] r_nrm [PLANES][3];
    logic signed [OFS_W-1:0]  r_ofs [PLANES];

    t_ctrl                       r_s1_ctrl;
    logic [2:0][COORD_BITS-1:0]  r_s1_lo;
    logic [2:0][COORD_BITS-1:0]  r_s1_hi;
    logic [RAD_W-1:0]            r_s1_rad;
    logic signed [PW-1:0]        r_plo [PLANES][3];
    logic signed [PW-1:0]        r_phi [PLANES][3];

    t_ctrl                       r_s2_ctrl;
    t_ctrl                       n_s2_ctrl;
    logic [2:0][COORD_BITS-1:0]  r_s2_lo;
    logic [2:0][COORD_BITS-1:0]  r_s2_hi;
    logic [RAD_W-1:0]            r_s2_rad;

    logic signed [DW-1:0]        d_max [PLANES];
    logic signed [DW-1:0]        d_min [PLANES];
    logic signed [DW-1:0]        d_lo  [PLANES];
    logic signed [DW-1:0]        rad_fx;
    logic [PLANES-1:0]           drop_k;
    logic [PLANES-1:0]           in_k;

    // plane store
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int a = 0; a < 3; a++) begin
                r_nrm[i_wr_plane][a] <= $signed(i_wr_normal[a]);
            end
            r_ofs[i_wr_plane] <= $signed(i_wr_offset);
        end
    end

    // stage 1: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctrl <= '0;
        end else if (i_adv) begin
            r_s1_ctrl <= i_ctrl;
        end
    end

    // stage 1: products of each normal with both box corners
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_lo  <= i_lo;
            r_s1_hi  <= i_hi;
            r_s1_rad <= i_rad;
            for (int k = 0; k < PLANES; k++) begin
                for (int a = 0; a < 3; a++) begin
                    r_plo[k][a] <= r_nrm[k][a] * $signed(i_lo[a]);
                    r_phi[k][a] <= r_nrm[k][a] * $signed(i_hi[a]);
                end
            end
        end
    end

    // stage 2: plane distances, near and far corner picked by normal sign
    assign rad_fx = DW'({r_s1_rad, {FRAC_BITS{1'b0}}});

    always_comb begin
        for (int k = 0; k < PLANES; k++) begin
            d_max[k] = DW'(r_ofs[k]);
            d_min[k] = DW'(r_ofs[k]);
            d_lo[k]  = DW'(r_ofs[k]);
            for (int a = 0; a < 3; a++) begin
                d_lo[k] = d_lo[k] + DW'(r_plo[k][a]);
                if (r_nrm[k][a] > 0) begin
                    d_max[k] = d_max[k] + DW'(r_phi[k][a]);
                    d_min[k] = d_min[k] + DW'(r_plo[k][a]);
                end else begin
                    d_max[k] = d_max[k] + DW'(r_plo[k][a]);
                    d_min[k] = d_min[k] + DW'(r_phi[k][a]);
                end
            end
            if (r_s1_ctrl.sphere) begin
                drop_k[k] = d_lo[k] < -rad_fx;
                in_k[k]   = d_lo[k] >= rad_fx;
            end else begin
                drop_k[k] = d_max[k] < 0;
                in_k[k]   = d_min[k] >= 0;
            end
        end
    end

    // mask update: outside drops this split, fully inside ends the search
    always_comb begin
        n_s2_ctrl = r_s1_ctrl;
        if (r_s1_ctrl.valid && !r_s1_ctrl.done && r_s1_ctrl.mask[CELL_IDX]) begin
            if (|drop_k) begin
                n_s2_ctrl.mask[CELL_IDX] = 1'b0;
            end else if (&in_k) begin
                n_s2_ctrl.mask = r_s1_ctrl.mask & KEEP_MASK;
                n_s2_ctrl.done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctrl <= '0;
        end else if (i_adv) begin
            r_s2_ctrl <= n_s2_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_lo  <= r_s1_lo;
            r_s2_hi  <= r_s1_hi;
            r_s2_rad <= r_s1_rad;
        end
    end

    assign o_ctrl = r_s2_ctrl;
    assign o_lo   = r_s2_lo;
    assign o_hi   = r_s2_hi;
    assign o_rad  = r_s2_rad;

endmodule

`default_nettype wire

[hw/rtl/cascade_split_frustum_cull.sv]
// Cascade split frustum cull.
// Input channel (i_valid / o_ready) carries plane writes and box or sphere
// tests; output channel (o_valid / i_ready) carries one split mask per test.
// Plane writes and unused commands produce no transfer.
// A test runs through a chain of MAX_SPLITS cells, one per split, two
// pipeline stages each (products, then sums and compare), so its mask
// passes both stages of every cell in turn and lands in the output register.
// One item is in the chain at a time: o_ready stays low from a test's
// transfer until its mask is loaded into the output register.
// A finished mask waits in the output register; the next item is taken
// meanwhile, and the chain only freezes when a second mask reaches its end
// before the first one is taken.
// Config: split_count at 0x0, cull_enable at 0x4, to be written by the user
// only while idle; the block itself does not enforce this.
// Reset: split_count = 3, cull_enable = 1, chain and output emptied. Plane
// registers are not cleared; test only against planes that were written.
// ----------------------------------------------------------------------------
// Cascade split cull - top level
// Input decode, config registers, the cell chain and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cascade_split_frustum_cull
    import csfc_pkg::*;
#(
    parameter int MAX_SPLITS = 4,
    parameter int COORD_BITS = 18
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item input
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_command,
    input  wire logic [3:0]                    i_plane_slot,
    input  wire logic signed [COORD_BITS-1:0]  i_first_x,
    input  wire logic signed [COORD_BITS-1:0]  i_first_y,
    input  wire logic signed [COORD_BITS-1:0]  i_first_z,
    input  wire logic signed [COORD_BITS-1:0]  i_second_x,
    input  wire logic signed [COORD_BITS-1:0]  i_second_y,
    input  wire logic signed [COORD_BITS-1:0]  i_second_z,
    input  wire logic signed [OFS_W-1:0]       i_plane_offset,
    input  wire logic [RAD_W-1:0]              i_sphere_radius,
    // result output
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [3:0]                         o_split_mask,
    // config port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_W-1:0]             paddr,
    input  wire logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]                  prdata,
    output logic                               pready
);

    localparam logic [3:0] MAX_N = 4'(MAX_SPLITS);

    logic        r_busy;
    logic        r_out_valid;
    logic [3:0]  r_out_mask;
    logic [2:0]  r_split_count;
    logic        r_cull_en;

    logic        acc;
    logic        start;
    logic        wr_sel;
    logic        cfg_wr;
    logic        adv;
    logic        load_out;
    logic [3:0]  eff_n;
    t_ctrl       entry_ctrl;
    logic [2:0][NORM_W-1:0] wr_normal;

    t_ctrl                       w_ctrl [MAX_SPLITS+1];
    logic [2:0][COORD_BITS-1:0]  w_lo   [MAX_SPLITS];
    logic [2:0][COORD_BITS-1:0]  w_hi   [MAX_SPLITS];
    logic [RAD_W-1:0]            w_rad  [MAX_SPLITS];

    // input decode
    assign o_ready = !r_busy;
    assign acc     = i_valid && o_ready;

    always_comb begin
        start  = 1'b0;
        wr_sel = 1'b0;
        case (i_command)
            CMD_WRITE_PLANE: wr_sel = acc;
            CMD_TEST_BOX:    start  = acc;
            CMD_TEST_SPHERE: start  = acc;
            default: begin
                start  = 1'b0;
                wr_sel = 1'b0;
            end
        endcase
    end

    // saturated normals for plane writes
    assign wr_normal[0] = sat_norm(33'(i_first_x));
    assign wr_normal[1] = sat_norm(33'(i_first_y));
    assign wr_normal[2] = sat_norm(33'(i_first_z));

    // active split count and starting mask
    assign eff_n = ({1'b0, r_split_count} > MAX_N) ? MAX_N : {1'b0, r_split_count};

    always_comb begin
        entry_ctrl        = '0;
        entry_ctrl.valid  = start;
        entry_ctrl.sphere = (i_command == CMD_TEST_SPHERE);
        entry_ctrl.done   = !r_cull_en;
        for (int b = 0; b < MASK_W; b++) begin
            entry_ctrl.mask[b] = 4'(b) < eff_n;
        end
    end

    // chain entry
    assign w_ctrl[0]   = entry_ctrl;
    assign w_lo[0][0]  = i_first_x;
    assign w_lo[0][1]  = i_first_y;
    assign w_lo[0][2]  = i_first_z;
    assign w_hi[0][0]  = i_second_x;
    assign w_hi[0][1]  = i_second_y;
    assign w_hi[0][2]  = i_second_z;
    assign w_rad[0]    = i_sphere_radius;

    // chain freezes only when a mask is done and the output is still full
    assign load_out = w_ctrl[MAX_SPLITS].valid && (!r_out_valid || i_ready);
    assign adv      = !w_ctrl[MAX_SPLITS].valid || load_out;

    // cell chain, one cell per split
    for (genvar i = 0; i < MAX_SPLITS; i++) begin : g_cell
        if (i < MAX_SPLITS - 1) begin : g_mid
            csfc_cell #(
                .COORD_BITS (COORD_BITS),
                .CELL_IDX   (i)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_adv       (adv),
                .i_wr_en     (wr_sel && (3'(i) == {1'b0, i_plane_slot[3:2]})),
                .i_wr_plane  (i_plane_slot[1:0]),
                .i_wr_normal (wr_normal),
                .i_wr_offset (i_plane_offset),
                .i_ctrl      (w_ctrl[i]),
                .i_lo        (w_lo[i]),
                .i_hi        (w_hi[i]),
                .i_rad       (w_rad[i]),
                .o_ctrl      (w_ctrl[i+1]),
                .o_lo        (w_lo[i+1]),
                .o_hi        (w_hi[i+1]),
                .o_rad       (w_rad[i+1])
            );
        end else begin : g_last
            csfc_cell #(
                .COORD_BITS (COORD_BITS),
                .CELL_IDX   (i)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_adv       (adv),
                .i_wr_en     (wr_sel && (3'(i) == {1'b0, i_plane_slot[3:2]})),
                .i_wr_plane  (i_plane_slot[1:0]),
                .i_wr_normal (wr_normal),
                .i_wr_offset (i_plane_offset),
                .i_ctrl      (w_ctrl[i]),
                .i_lo        (w_lo[i]),
                .i_hi        (w_hi[i]),
                .i_rad       (w_rad[i]),
                .o_ctrl      (w_ctrl[i+1]),
                .o_lo        (),
                .o_hi        (),
                .o_rad       ()
            );
        end
    end

    // busy from test transfer until its mask reaches the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (start) begin
            r_busy <= 1'b1;
        end else if (load_out) begin
            r_busy <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_mask <= w_ctrl[MAX_SPLITS].mask[3:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_split_mask = r_out_mask;

    // config registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_count <= 3'd3;
            r_cull_en     <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SPLIT_COUNT: r_split_count <= pwdata[2:0];
                REG_CULL_ENABLE: r_cull_en     <= pwdata[0];
                default:         r_cull_en     <= r_cull_en;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SPLIT_COUNT: prdata = DATA_W'(r_split_count);
            REG_CULL_ENABLE: prdata = DATA_W'(r_cull_en);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/csfc_chk.sv]
// ----------------------------------------------------------------------------
// Cascade split cull - port checker
// Watches the item channels of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cascade_split_frustum_cull_defines.svh"

module csfc_chk
    import csfc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [1:0] i_command,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [3:0] o_split_mask
);

    // a stalled mask holds
    `CSFC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_split_mask)))

    // a test transfer makes the block busy
    `CSFC_ASSERT(a_test_busy, i_clk, i_rst_n, (i_valid && o_ready && (i_command == CMD_TEST_BOX || i_command == CMD_TEST_SPHERE)) |=> !o_ready)

    // a plane write or unused command never creates a result
    `CSFC_ASSERT(a_write_quiet, i_clk, i_rst_n, (i_valid && o_ready && !o_valid && !(i_command == CMD_TEST_BOX || i_command == CMD_TEST_SPHERE)) |=> !o_valid)

    // reset empties the block
    `CSFC_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> (!o_valid && o_ready))

endmodule

bind cascade_split_frustum_cull csfc_chk u_csfc_chk (.*);

`default_nettype wire

[sim/cascade_split_frustum_cull_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascade split cull - testbench
// Loads all sixteen cull planes, then runs box and sphere tests through the
// block under several split counts and with culling on and off. A scoreboard
// keeps its own copy of the planes and registers, works out the split mask of
// every test at the input transfer, and compares each output transfer with
// the oldest mask still owed. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module cascade_split_frustum_cull_tb;
    import csfc_pkg::*;

    localparam int MAX_SPLITS  = 4;
    localparam int COORD_BITS  = 18;
    localparam int SLOTS       = MAX_SPLITS * PLANES;
    localparam int HOLD_CYCLES = 2 * MAX_SPLITS + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_ITEMS   = 54;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = 18'sd131071;
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = -18'sd131072;
    localparam logic signed [COORD_BITS-1:0] FIRST_MIN = -18'sd32768;
    localparam logic signed [OFS_W-1:0]      OFS_MAX   = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic signed [OFS_W-1:0]      OFS_MIN   = {1'b1, {(OFS_W-1){1'b0}}};

    typedef struct {
        logic [1:0]                   command;
        logic [3:0]                   plane_slot;
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] first_z;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] second_z;
        logic signed [OFS_W-1:0]      plane_offset;
        logic [RAD_W-1:0]             sphere_radius;
    } t_cull_item;

    // Plane store, registers and the masks still owed by the block
    class t_cull_tracker;
        int          nrm [SLOTS][3];
        longint      ofs [SLOTS];
        int unsigned split_count;
        bit          cull_on;
        logic [3:0]  pending_masks [$];
        int          errors;

        function new();
            foreach (nrm[s, a]) nrm[s][a] = 0;
            foreach (ofs[s]) ofs[s] = 0;
            split_count = 3;
            cull_on     = 1'b1;
            errors      = 0;
        endfunction

        function void set_reg(t_reg idx, int unsigned val);
            if (idx == REG_SPLIT_COUNT) begin
                split_count = val & 7;
            end else begin
                cull_on = val[0];
            end
        endfunction

        // normals are stored saturated to Q1.15
        function int clamp_q15(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return int'(v);
        endfunction

        function longint plane_dist(int s, longint x, longint y, longint z);
            return nrm[s][0] * x + nrm[s][1] * y + nrm[s][2] * z + ofs[s];
        endfunction

        function logic [3:0] split_mask_for(t_cull_item it);
            int unsigned n;
            logic [7:0]  m;
            longint      lo [3];
            longint      hi [3];
            longint      r;
            longint      dmax;
            longint      dmin;
            bit          drop;
            bit          fully_in;
            int          s;
            n = (split_count > MAX_SPLITS) ? MAX_SPLITS : split_count;
            m = (8'd1 << n) - 8'd1;
            if (cull_on) begin
                lo[0] = it.first_x;  lo[1] = it.first_y;  lo[2] = it.first_z;
                hi[0] = it.second_x; hi[1] = it.second_y; hi[2] = it.second_z;
                r = longint'(it.sphere_radius) * 32768;
                for (int i = 0; i < n; i++) begin
                    drop     = 1'b0;
                    fully_in = 1'b1;
                    for (int k = 0; k < PLANES; k++) begin
                        s = i * PLANES + k;
                        if (it.command == CMD_TEST_BOX) begin
                            // far corner along the normal decides outside,
                            // near corner decides inside
                            dmax = plane_dist(s, nrm[s][0] > 0 ? hi[0] : lo[0],
                                                 nrm[s][1] > 0 ? hi[1] : lo[1],
                                                 nrm[s][2] > 0 ? hi[2] : lo[2]);
                            dmin = plane_dist(s, nrm[s][0] > 0 ? lo[0] : hi[0],
                                                 nrm[s][1] > 0 ? lo[1] : hi[1],
                                                 nrm[s][2] > 0 ? lo[2] : hi[2]);
                            if (dmax < 0) begin
                                drop = 1'b1;
                                break;
                            end
                            if (dmin < 0) fully_in = 1'b0;
                        end else begin
                            dmax = plane_dist(s, lo[0], lo[1], lo[2]);
                            if (dmax < -r) begin
                                drop = 1'b1;
                                break;
                            end
                            if (dmax < r) fully_in = 1'b0;
                        end
                    end
                    if (drop) begin
                        m[i] = 1'b0;
                    end else if (fully_in) begin
                        // wholly inside: later splits are cleared
                        m = m & ((8'd2 << i) - 8'd1);
                        break;
                    end
                end
            end
            return m[3:0];
        endfunction

        function void note_item(t_cull_item it);
            if (it.command == CMD_WRITE_PLANE) begin
                nrm[it.plane_slot][0] = clamp_q15(it.first_x);
                nrm[it.plane_slot][1] = clamp_q15(it.first_y);
                nrm[it.plane_slot][2] = clamp_q15(it.first_z);
                ofs[it.plane_slot]    = it.plane_offset;
            end else if (it.command != CMD_UNUSED) begin
                pending_masks.push_back(split_mask_for(it));
            end
        endfunction

        function void check_mask(logic [3:0] got);
            logic [3:0] want;
            if (pending_masks.size() == 0) begin
                $display("%0t: split mask %h arrived with none expected", $time, got);
                errors++;
            end else begin
                want = pending_masks.pop_front();
                if (got !== want) begin
                    $display("%0t: split mask expected %h, actual %h", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                         i_valid         = 1'b0;
    logic                         o_ready;
    logic [1:0]                   i_command       = '0;
    logic [3:0]                   i_plane_slot    = '0;
    logic signed [COORD_BITS-1:0] i_first_x       = '0;
    logic signed [COORD_BITS-1:0] i_first_y       = '0;
    logic signed [COORD_BITS-1:0] i_first_z       = '0;
    logic signed [COORD_BITS-1:0] i_second_x      = '0;
    logic signed [COORD_BITS-1:0] i_second_y      = '0;
    logic signed [COORD_BITS-1:0] i_second_z      = '0;
    logic signed [OFS_W-1:0]      i_plane_offset  = '0;
    logic [RAD_W-1:0]             i_sphere_radius = '0;
    logic                         o_valid;
    logic                         i_ready         = 1'b0;
    logic [3:0]                   o_split_mask;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_cull_tracker board;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    int            cycles        = 0;

    // split count and cull enable per segment, extremes included
    int unsigned seg_count [12] = '{4, 1, 0, 3, 7, 2, 4, 5, 3, 1, 6, 4};
    bit          seg_cull  [12] = '{1, 1, 1, 0, 1, 1, 0, 1, 1, 0, 1, 1};
    int          idle_tab  [3]  = '{26, 77, 0};
    int          stall_tab [3]  = '{77, 26, 0};

    cascade_split_frustum_cull #(
        .MAX_SPLITS (MAX_SPLITS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_plane_slot    (i_plane_slot),
        .i_first_x       (i_first_x),
        .i_first_y       (i_first_y),
        .i_first_z       (i_first_z),
        .i_second_x      (i_second_x),
        .i_second_y      (i_second_y),
        .i_second_z      (i_second_z),
        .i_plane_offset  (i_plane_offset),
        .i_sphere_radius (i_sphere_radius),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_split_mask    (o_split_mask),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls at the current rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_mask(o_split_mask);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d split masks owed", $time,
                     board.pending_masks.size());
            $display("FAIL cascade_split_frustum_cull");
            $finish;
        end
    end

    // every field random over its full range, but first_x and first_y only from -32768 up
    function automatic t_cull_item wild_item(logic [1:0] cmd);
        t_cull_item it;
        it.command       = cmd;
        it.plane_slot    = 4'($urandom_range(SLOTS - 1));
        it.first_x       = COORD_BITS'(int'($urandom_range(163839)) - 32768);
        it.first_y       = COORD_BITS'(int'($urandom_range(163839)) - 32768);
        it.first_z       = COORD_BITS'($urandom);
        it.second_x      = COORD_BITS'($urandom);
        it.second_y      = COORD_BITS'($urandom);
        it.second_z      = COORD_BITS'($urandom);
        it.plane_offset  = OFS_W'({$urandom, $urandom});
        it.sphere_radius = RAD_W'($urandom);
        return it;
    endfunction

    // plane that cuts through the region where tame objects sit
    function automatic t_cull_item tame_plane(t_cull_item it);
        it.first_x      = COORD_BITS'(int'($urandom_range(65534)) - 32767);
        it.first_y      = COORD_BITS'(int'($urandom_range(65534)) - 32767);
        it.first_z      = COORD_BITS'(int'($urandom_range(65534)) - 32767);
        it.plane_offset = OFS_W'(longint'($urandom_range(131072000)) - 64'sd16384000);
        return it;
    endfunction

    // small object near the origin; now and then an inverted box
    function automatic t_cull_item tame_object(t_cull_item it);
        int c [3];
        int w [3];
        foreach (c[a]) begin
            c[a] = int'($urandom_range(2000)) - 1000;
            w[a] = $urandom_range(200);
        end
        if ($urandom_range(9) == 0) w[$urandom_range(2)] = -int'($urandom_range(100, 1));
        it.first_x       = COORD_BITS'(c[0]);
        it.first_y       = COORD_BITS'(c[1]);
        it.first_z       = COORD_BITS'(c[2]);
        it.second_x      = COORD_BITS'(c[0] + w[0]);
        it.second_y      = COORD_BITS'(c[1] + w[1]);
        it.second_z      = COORD_BITS'(c[2] + w[2]);
        it.sphere_radius = RAD_W'($urandom_range(300));
        return it;
    endfunction

    function automatic t_cull_item random_item();
        t_cull_item  it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            it = wild_item(CMD_UNUSED);
        end else if (pick < 13) begin
            it = wild_item(CMD_WRITE_PLANE);
            if ($urandom_range(4) != 0) it = tame_plane(it);
        end else begin
            it = wild_item($urandom_range(1) ? CMD_TEST_SPHERE : CMD_TEST_BOX);
            if ($urandom_range(6) != 0) it = tame_object(it);
        end
        return it;
    endfunction

    // one input transfer, then random idle cycles
    task automatic push_item(input t_cull_item it);
        i_valid         <= 1'b1;
        i_command       <= it.command;
        i_plane_slot    <= it.plane_slot;
        i_first_x       <= it.first_x;
        i_first_y       <= it.first_y;
        i_first_z       <= it.first_z;
        i_second_x      <= it.second_x;
        i_second_y      <= it.second_y;
        i_second_z      <= it.second_z;
        i_plane_offset  <= it.plane_offset;
        i_sphere_radius <= it.sphere_radius;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_item(it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic apb_write(input t_reg idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.set_reg(idx, val);
    endtask

    // stop sending, let every owed mask arrive, then let the chain empty
    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending_masks.size() != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_cull_item it;
        int         sent;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // load every plane; saturating normals, zero normal, offset extremes
        for (int s = 0; s < SLOTS; s++) begin
            it = tame_plane(wild_item(CMD_WRITE_PLANE));
            it.plane_slot = 4'(s);
            case (s)
                0: it.first_x = COORD_MAX;
                3: begin
                    it.first_x      = '0;
                    it.first_y      = '0;
                    it.first_z      = '0;
                    it.plane_offset = 41'sd32768;
                end
                5: it.first_z = COORD_MIN;
                14: it.plane_offset = OFS_MIN;
                15: it.plane_offset = OFS_MAX;
                default: ;
            endcase
            push_item(it);
        end

        // directed tests under the reset register values
        push_item(tame_object(wild_item(CMD_TEST_BOX)));
        it = tame_object(wild_item(CMD_TEST_SPHERE));
        it.sphere_radius = '0;
        push_item(it);
        it = tame_object(wild_item(CMD_TEST_SPHERE));
        it.sphere_radius = '1;
        push_item(it);
        it = wild_item(CMD_TEST_BOX);
        it.first_x  = 18'sd100;  it.first_y  = 18'sd50;  it.first_z  = 18'sd200;
        it.second_x = -18'sd100; it.second_y = -18'sd50; it.second_z = -18'sd200;
        push_item(it);
        it = wild_item(CMD_TEST_BOX);
        it.first_x  = FIRST_MIN; it.first_y  = FIRST_MIN; it.first_z  = COORD_MIN;
        it.second_x = COORD_MAX; it.second_y = COORD_MAX; it.second_z = COORD_MAX;
        push_item(it);
        it = wild_item(CMD_TEST_SPHERE);
        it.first_x = COORD_MAX;
        it.first_y = COORD_MAX;
        it.first_z = COORD_MIN;
        push_item(it);
        push_item(wild_item(CMD_UNUSED));
        it = wild_item(CMD_TEST_BOX);
        it.first_x  = COORD_MAX; it.first_y  = COORD_MAX; it.first_z  = COORD_MAX;
        it.second_x = COORD_MAX; it.second_y = COORD_MAX; it.second_z = COORD_MAX;
        push_item(it);

        // random segments: three idle patterns, four register settings each
        for (int ph = 0; ph < 3; ph++) begin
            for (int g = 0; g < 4; g++) begin
                settle();
                apb_write(REG_SPLIT_COUNT, seg_count[ph * 4 + g]);
                apb_write(REG_CULL_ENABLE, seg_cull[ph * 4 + g]);
                send_idle_pct = idle_tab[ph];
                stall_pct     = stall_tab[ph];
                sent = 0;
                while (sent < SEG_ITEMS) begin
                    it = random_item();
                    push_item(it);
                    if (it.command != CMD_UNUSED) sent++;
                end
            end
        end

        settle();
        if (board.errors == 0) begin
            $display("PASS cascade_split_frustum_cull");
        end else begin
            $display("FAIL cascade_split_frustum_cull");
        end
        $finish;
    end

endmodule
